>>> rtl/core/text_console_char_and_decimal_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_AND_DECIMAL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_AND_DECIMAL_WRITER_MACROS_SVH

// A property that must hold in the same cycle.
`define TCCW_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, character codes, command kinds and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    // Default screen geometry and digit capacity.
    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int MAX_DIGITS_DEF = 10;

    // Fixed field widths.
    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int NUMBER_W  = 31;
    localparam int ROW_IN_W  = 5;
    localparam int COL_IN_W  = 7;
    localparam int CELL_W    = 11;
    localparam int COL_MAX_W = 7;
    localparam int ROW_MAX_W = 6;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TILDE   = 8'd126;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;

    // Input function codes.
    localparam logic [FUNC_W-1:0] FUNC_CHAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COLOR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NUMBER = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CURSOR = 2'd3;

    // Classified command kinds.
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_NUMBER  = 2'd2;
    localparam logic [1:0] KIND_CURSOR  = 2'd3;

    // One classified command as held in the queue.
    typedef struct packed {
        logic [1:0]           kind;
        logic [CHAR_W-1:0]    glyph;
        logic [CHAR_W-1:0]    attribute;
        logic                 attribute_valid;
        logic [NUMBER_W-1:0]  number;
        logic [ROW_MAX_W-1:0] row;
        logic [COL_MAX_W-1:0] column;
    } t_cmd;

    // Queue fill status.
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_queue_status;

    // Back part status and cursor position.
    typedef struct packed {
        logic                 busy;
        logic [COL_MAX_W-1:0] column;
        logic [ROW_MAX_W-1:0] row;
    } t_back_status;

endpackage

`default_nettype wire

>>> rtl/core/tccw_if.sv
// ----------------------------------------------------------------------------
// Text console writer channel interfaces
// Valid/ready channels for command items and cell write items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tccw_in_if import tccw_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CHAR_W-1:0]   char_code;
    logic [CHAR_W-1:0]   color;
    logic [NUMBER_W-1:0] number;
    logic [ROW_IN_W-1:0] row;
    logic [COL_IN_W-1:0] column;

    modport source (output valid, func, char_code, color, number, row, column,
                    input ready);
    modport sink   (input valid, func, char_code, color, number, row, column,
                    output ready);
endinterface

interface tccw_out_if import tccw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_index;
    logic [CHAR_W-1:0] glyph;
    logic [CHAR_W-1:0] attribute;
    logic              attribute_valid;
    logic              last;

    modport source (output valid, cell_index, glyph, attribute, attribute_valid, last,
                    input ready);
    modport sink   (input valid, cell_index, glyph, attribute, attribute_valid, last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/tccw_front.sv
// ----------------------------------------------------------------------------
// Text console writer front part
// Accepts command items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_front import tccw_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tccw_in_if.sink      i_cmd,
    output t_cmd          o_head,
    output logic          o_head_valid,
    input  wire logic    i_pop,
    output t_queue_status o_status
);

    t_cmd              n_entry;
    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic              push;
    logic              pop;

    // Classify the incoming item and saturate the cursor target.
    always_comb begin
        n_entry                 = '0;
        n_entry.glyph           = i_cmd.char_code;
        n_entry.number          = i_cmd.number;
        n_entry.attribute_valid = (i_cmd.func == FUNC_COLOR);
        n_entry.attribute       = (i_cmd.func == FUNC_COLOR) ? i_cmd.color : '0;
        case (i_cmd.func)
            FUNC_CHAR, FUNC_COLOR: begin
                if (i_cmd.char_code == CH_NEWLINE || i_cmd.char_code == CH_TILDE) begin
                    n_entry.kind = KIND_NEWLINE;
                end else begin
                    n_entry.kind = KIND_WRITE;
                end
            end
            FUNC_NUMBER: n_entry.kind = KIND_NUMBER;
            FUNC_CURSOR: n_entry.kind = KIND_CURSOR;
            default:     n_entry.kind = KIND_CURSOR;
        endcase
        if (32'(i_cmd.row) >= ROWS) begin
            n_entry.row = ROW_MAX_W'(ROWS - 1);
        end else begin
            n_entry.row = ROW_MAX_W'(i_cmd.row);
        end
        if (32'(i_cmd.column) >= COLUMNS) begin
            n_entry.column = COL_MAX_W'(COLUMNS - 1);
        end else begin
            n_entry.column = COL_MAX_W'(i_cmd.column);
        end
    end

    // Queue handshakes.
    assign i_cmd.ready  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push         = i_cmd.valid && i_cmd.ready;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_queue[r_rd];

    // Pointer advance with wrap at the queue depth.
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (push) begin
            n_wr = (32'(r_wr) == QUEUE_DEPTH - 1) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (32'(r_rd) == QUEUE_DEPTH - 1) ? '0 : r_rd + 1'b1;
        end
    end

    // Queue control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr] <= n_entry;
        end
    end

    assign o_status.count = r_count;
    assign o_status.full  = !i_cmd.ready;
    assign o_status.empty = !o_head_valid;

endmodule

`default_nettype wire

>>> rtl/core/tccw_back.sv
// ----------------------------------------------------------------------------
// Text console writer back part
// Carries out commands: cursor moves, cell writes and decimal printing.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_back import tccw_pkg::*; #(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cmd    i_head,
    input  wire logic   i_head_valid,
    output logic         o_pop,
    tccw_out_if.source  o_cell,
    output t_back_status o_status
);

    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int DIG_W  = $clog2(MAX_DIGITS);
    localparam int BITS_W = $clog2(NUMBER_W + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       n_col;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       n_row;
    logic [NUMBER_W-1:0] r_shift;
    logic [NUMBER_W-1:0] n_shift;
    logic [BITS_W-1:0]   r_bits;
    logic [BITS_W-1:0]   n_bits;
    logic [DIG_W-1:0]    r_idx;
    logic [DIG_W-1:0]    n_idx;
    logic                r_started;
    logic                n_started;
    logic [3:0]          r_bcd   [MAX_DIGITS];
    logic [3:0]          adj     [MAX_DIGITS];
    logic [3:0]          dab_bcd [MAX_DIGITS];
    logic                bcd_load;
    logic                bcd_step;

    logic                r_out_valid;
    logic [CELL_W-1:0]   r_out_cell;
    logic [CHAR_W-1:0]   r_out_glyph;
    logic [CHAR_W-1:0]   r_out_attr;
    logic                r_out_attr_valid;
    logic                r_out_last;
    logic                load_out;
    logic [CHAR_W-1:0]   n_out_glyph;
    logic [CHAR_W-1:0]   n_out_attr;
    logic                n_out_attr_valid;
    logic                n_out_last;

    logic                slot_free;
    logic                col_wrap;
    logic                row_wrap;
    logic [CW-1:0]       adv_col;
    logic [RW-1:0]       adv_row;
    logic [RW-1:0]       nl_row;
    logic [31:0]         cell_full;
    logic [3:0]          digit;

    assign slot_free = !r_out_valid || o_cell.ready;

    // Cursor advance after a write and the row after a line break.
    assign col_wrap  = ((CW + 1)'(r_col) + 1'b1) == (CW + 1)'(COLUMNS);
    assign row_wrap  = ((RW + 1)'(r_row) + 1'b1) == (RW + 1)'(ROWS);
    assign nl_row    = row_wrap ? '0 : r_row + 1'b1;
    assign adv_col   = col_wrap ? '0 : r_col + 1'b1;
    assign adv_row   = col_wrap ? nl_row : r_row;
    assign cell_full = 32'(r_row) * 32'(COLUMNS) + 32'(r_col);
    assign digit     = r_bcd[r_idx];

    // One double-dabble step: add three to every digit of five or more, then shift.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            adj[d] = (r_bcd[d] >= 4'd5) ? r_bcd[d] + 4'd3 : r_bcd[d];
        end
        dab_bcd[0] = {adj[0][2:0], r_shift[NUMBER_W-1]};
        for (int d = 1; d < MAX_DIGITS; d++) begin
            dab_bcd[d] = {adj[d][2:0], adj[d-1][3]};
        end
    end

    // Command sequencer.
    always_comb begin
        n_state          = r_state;
        n_col            = r_col;
        n_row            = r_row;
        n_shift          = r_shift;
        n_bits           = r_bits;
        n_idx            = r_idx;
        n_started        = r_started;
        o_pop            = 1'b0;
        bcd_load         = 1'b0;
        bcd_step         = 1'b0;
        load_out         = 1'b0;
        n_out_glyph      = i_head.glyph;
        n_out_attr       = i_head.attribute;
        n_out_attr_valid = i_head.attribute_valid;
        n_out_last       = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_head_valid && slot_free) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        KIND_WRITE: begin
                            load_out = 1'b1;
                            n_col    = adv_col;
                            n_row    = adv_row;
                        end
                        KIND_NEWLINE: begin
                            n_col = '0;
                            n_row = nl_row;
                        end
                        KIND_NUMBER: begin
                            n_shift  = i_head.number;
                            n_bits   = BITS_W'(NUMBER_W);
                            bcd_load = 1'b1;
                            n_state  = S_CONV;
                        end
                        KIND_CURSOR: begin
                            n_col = i_head.column[CW-1:0];
                            n_row = i_head.row[RW-1:0];
                        end
                        default: ;
                    endcase
                end
            end
            S_CONV: begin
                bcd_step = 1'b1;
                n_shift  = {r_shift[NUMBER_W-2:0], 1'b0};
                n_bits   = r_bits - 1'b1;
                if (r_bits == BITS_W'(1)) begin
                    n_idx     = DIG_W'(MAX_DIGITS - 1);
                    n_started = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                // Leading zeros are skipped; the units digit is always printed.
                if (!r_started && digit == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end else if (slot_free) begin
                    load_out         = 1'b1;
                    n_out_glyph      = CH_ZERO + {4'b0000, digit};
                    n_out_attr       = '0;
                    n_out_attr_valid = 1'b0;
                    n_out_last       = (r_idx == '0);
                    n_col            = adv_col;
                    n_row            = adv_row;
                    n_started        = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and cursor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_bits      <= '0;
            r_idx       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_bits    <= n_bits;
            r_idx     <= n_idx;
            r_started <= n_started;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_cell.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Conversion data path and result payload.
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd_load) begin
                r_bcd[d] <= 4'd0;
            end else if (bcd_step) begin
                r_bcd[d] <= dab_bcd[d];
            end
        end
        if (load_out) begin
            r_out_cell       <= cell_full[CELL_W-1:0];
            r_out_glyph      <= n_out_glyph;
            r_out_attr       <= n_out_attr;
            r_out_attr_valid <= n_out_attr_valid;
            r_out_last       <= n_out_last;
        end
    end

    assign o_cell.valid           = r_out_valid;
    assign o_cell.cell_index      = r_out_cell;
    assign o_cell.glyph           = r_out_glyph;
    assign o_cell.attribute       = r_out_attr;
    assign o_cell.attribute_valid = r_out_attr_valid;
    assign o_cell.last            = r_out_last;

    assign o_status.busy   = (r_state != S_IDLE) || r_out_valid;
    assign o_status.column = COL_MAX_W'(r_col);
    assign o_status.row    = ROW_MAX_W'(r_row);

endmodule

`default_nettype wire

>>> rtl/core/text_console_char_and_decimal_writer.sv
// A character item passes through the command queue and is then held in the output register.
// Throughput: character, newline and cursor items sustain one item per cycle while the output slot is free.
// A number item runs 31 double-dabble steps, then visits each digit position from the top down,
// skipping leading zeros and writing the rest; the next queued item waits until it is done.
// Reset: synchronous active-low i_rst_n clears the cursor to the top left, the queue and output.
// ----------------------------------------------------------------------------
// Text console character and decimal writer
// Front part classifies command items into a queue; back part moves the
// cursor and writes screen cells, printing numbers as decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_and_decimal_writer_macros.svh"

module text_console_char_and_decimal_writer import tccw_pkg::*; #(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tccw_in_if.sink    i_cmd,
    tccw_out_if.source o_cell
);

    t_cmd          head;
    logic          head_valid;
    logic          pop;
    t_queue_status q_status;
    t_back_status  back_status;

    // Accept and classify items.
    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop),
        .o_status     (q_status)
    );

    // Execute commands and drive cell writes.
    tccw_back #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_cell       (o_cell),
        .o_status     (back_status)
    );

    // Checks on cursor range, queue behavior and result fields.
    `TCCW_ASSERT_NOW(a_cursor_in_range, 32'(back_status.column) < COLUMNS && 32'(back_status.row) < ROWS, "cursor outside the screen")
    `TCCW_ASSERT_NOW(a_queue_bound, 32'(q_status.count) <= QUEUE_DEPTH && q_status.full == (32'(q_status.count) == QUEUE_DEPTH), "queue count above depth or full flag wrong")
    `TCCW_ASSERT_NEXT(a_push_lands, i_cmd.valid && i_cmd.ready, !q_status.empty, "accepted item missing from queue")
    `TCCW_ASSERT_NOW(a_color_single, !(o_cell.valid && o_cell.attribute_valid) || o_cell.last, "colored write not last")
    `TCCW_ASSERT_NOW(a_attr_zero, !o_cell.valid || (back_status.busy && (o_cell.attribute_valid || o_cell.attribute == '0)), "attribute set without valid or write while idle")

endmodule

`default_nettype wire

>>> tb/text_console_char_and_decimal_writer_test.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends character, colored character, number and cursor commands and checks
// every cell write against a cursor and digit predictor kept in the bench,
// under random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module text_console_char_and_decimal_writer_test import tccw_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_CYCLES = 250;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_LIMIT = 10;

    // One command as offered on the input channel.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CHAR_W-1:0]   char_code;
        logic [CHAR_W-1:0]   color;
        logic [NUMBER_W-1:0] number;
        logic [ROW_IN_W-1:0] row;
        logic [COL_IN_W-1:0] column;
    } t_cmd_item;

    // One screen cell write as seen on the output channel.
    typedef struct packed {
        logic [CELL_W-1:0] cell_index;
        logic [CHAR_W-1:0] glyph;
        logic [CHAR_W-1:0] attribute;
        logic              attribute_valid;
        logic              last;
    } t_cell_write;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tccw_in_if  cmd_if ();
    tccw_out_if cell_if ();

    text_console_char_and_decimal_writer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_cell  (cell_if)
    );

    // Predicted cursor position and the cell writes still owed by the block.
    logic [COL_MAX_W-1:0] cursor_col;
    logic [ROW_MAX_W-1:0] cursor_row;
    t_cell_write          owed_writes[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int commands_sent  = 0;
    int writes_checked = 0;
    int error_count    = 0;
    logic stall_request = 1'b0;
    int   stall_left    = 0;

    always #5 i_clk = ~i_clk;

    // Move the predicted cursor to the start of the next row.
    function automatic void advance_line();
        cursor_col = '0;
        cursor_row = (cursor_row == ROWS_DEF - 1) ? '0 : cursor_row + 1'b1;
    endfunction

    // Queue one cell write at the cursor and step the cursor forward.
    function automatic void record_write(input logic [CHAR_W-1:0] glyph,
                                         input logic [CHAR_W-1:0] attr,
                                         input logic attr_valid, input logic last);
        t_cell_write w;
        w.cell_index      = CELL_W'(cursor_row * COLUMNS_DEF + cursor_col);
        w.glyph           = glyph;
        w.attribute       = attr_valid ? attr : '0;
        w.attribute_valid = attr_valid;
        w.last            = last;
        owed_writes.push_back(w);
        if (cursor_col == COLUMNS_DEF - 1) begin
            advance_line();
        end else begin
            cursor_col = cursor_col + 1'b1;
        end
    endfunction

    // Work out the cell writes that one accepted command causes.
    function automatic void predict_command(input t_cmd_item c);
        logic [3:0]          digits[MAX_DIGITS_DEF];
        logic [NUMBER_W-1:0] value;
        int                  ndigits;
        case (c.func)
            FUNC_CHAR, FUNC_COLOR: begin
                if (c.char_code == CH_NEWLINE || c.char_code == CH_TILDE) begin
                    advance_line();
                end else begin
                    record_write(c.char_code, c.color, c.func == FUNC_COLOR, 1'b1);
                end
            end
            FUNC_NUMBER: begin
                // Split into decimal digits; zero gives a single digit.
                value   = c.number;
                ndigits = 0;
                do begin
                    digits[ndigits] = 4'(value % 10);
                    value           = value / 10;
                    ndigits++;
                end while (value != 0);
                for (int i = ndigits - 1; i >= 0; i--) begin
                    record_write(CHAR_W'(CH_ZERO + digits[i]), '0, 1'b0, i == 0);
                end
            end
            default: begin
                // Out of range positions saturate to the last row or column.
                cursor_row = (c.row >= ROWS_DEF) ? ROW_MAX_W'(ROWS_DEF - 1)
                                                 : ROW_MAX_W'(c.row);
                cursor_col = (c.column >= COLUMNS_DEF) ? COL_MAX_W'(COLUMNS_DEF - 1)
                                                       : COL_MAX_W'(c.column);
            end
        endcase
    endfunction

    // A command with every field random; numbers spread over all magnitudes.
    function automatic t_cmd_item random_command();
        t_cmd_item c;
        c.func      = FUNC_W'($urandom_range(3));
        c.char_code = CHAR_W'($urandom);
        if ($urandom_range(7) == 0) begin
            c.char_code = $urandom_range(1) ? CH_NEWLINE : CH_TILDE;
        end
        c.color  = CHAR_W'($urandom);
        c.number = NUMBER_W'($urandom) >> $urandom_range(NUMBER_W - 1);
        c.row    = ROW_IN_W'($urandom);
        c.column = COL_IN_W'($urandom);
        return c;
    endfunction

    // Offer one command after a random gap and wait until it is taken.
    task automatic send_command(input t_cmd_item c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.func      <= c.func;
        cmd_if.char_code <= c.char_code;
        cmd_if.color     <= c.color;
        cmd_if.number    <= c.number;
        cmd_if.row       <= c.row;
        cmd_if.column    <= c.column;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predict_command(c);
        commands_sent++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        t_cmd_item c;
        c           = random_command();
        c.func      = FUNC_CHAR;
        c.char_code = ch;
        send_command(c);
    endtask

    task automatic put_colored(input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] attr);
        t_cmd_item c;
        c           = random_command();
        c.func      = FUNC_COLOR;
        c.char_code = ch;
        c.color     = attr;
        send_command(c);
    endtask

    task automatic put_number(input logic [NUMBER_W-1:0] value);
        t_cmd_item c;
        c        = random_command();
        c.func   = FUNC_NUMBER;
        c.number = value;
        send_command(c);
    endtask

    task automatic put_cursor(input logic [ROW_IN_W-1:0] r, input logic [COL_IN_W-1:0] col);
        t_cmd_item c;
        c        = random_command();
        c.func   = FUNC_CURSOR;
        c.row    = r;
        c.column = col;
        send_command(c);
    endtask

    // Plain and colored characters at the byte extremes, newline and tilde.
    task automatic test_character_writes();
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_colored(8'h5A, 8'hFF);
        put_colored(8'hA5, 8'h00);
        put_char(CH_NEWLINE);
        put_colored(CH_TILDE, 8'h3C);
        put_char(CH_TILDE);
    endtask

    // Zero, a single digit, the largest value and a long run of zeros.
    task automatic test_number_printing();
        put_number('0);
        put_number(31'd7);
        put_number(31'h7FFF_FFFF);
        put_number(31'd1_000_000_000);
        put_number(31'd9);
    endtask

    // Line wrap, bottom wrap, saturation, newline on the last row and a
    // number that wraps around the bottom of the screen part way through.
    task automatic test_cursor_moves();
        put_cursor(5'd0, 7'd78);
        put_char(8'h31);
        put_char(8'h32);
        put_char(8'h33);
        put_cursor(5'd24, 7'd79);
        put_char(8'h7E - 8'd1);
        put_cursor(5'd31, 7'd127);
        put_colored(8'h40, 8'h81);
        put_cursor(5'd24, 7'd0);
        put_char(CH_NEWLINE);
        put_cursor(5'd24, 7'd75);
        put_number(31'h7FFF_FFFF);
    endtask

    task automatic test_random_commands(input int count);
        for (int i = 0; i < count; i++) begin
            send_command(random_command());
        end
    endtask

    // Hold the output off for a long stretch while numbers keep arriving,
    // so that the command queue fills and the input stalls.
    task automatic test_input_stall();
        t_cmd_item c;
        cmd_if.valid  <= 1'b0;
        stall_request <= 1'b1;
        @(posedge i_clk);
        stall_request <= 1'b0;
        for (int i = 0; i < 10; i++) begin
            c = random_command();
            if (i % 3 != 2) begin
                c.func = FUNC_NUMBER;
            end
            send_command(c);
        end
    endtask

    // Count down a requested output stall.
    always @(posedge i_clk) begin
        if (stall_request) begin
            stall_left <= STALL_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Take cell writes, compare each with the oldest owed write, then pick
    // the next ready value.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_if.ready <= 1'b0;
        end else begin
            if (cell_if.valid && cell_if.ready) begin
                writes_checked++;
                if (owed_writes.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("ERROR: unexpected write cell=%0d glyph=%02h",
                                 cell_if.cell_index, cell_if.glyph);
                    end
                end else if (cell_if.cell_index != owed_writes[0].cell_index
                             || cell_if.glyph != owed_writes[0].glyph
                             || cell_if.attribute != owed_writes[0].attribute
                             || cell_if.attribute_valid != owed_writes[0].attribute_valid
                             || cell_if.last != owed_writes[0].last) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("ERROR: write %0d expected cell=%0d glyph=%02h attr=%02h/%0b last=%0b",
                                 writes_checked, owed_writes[0].cell_index,
                                 owed_writes[0].glyph, owed_writes[0].attribute,
                                 owed_writes[0].attribute_valid, owed_writes[0].last);
                        $display("       got cell=%0d glyph=%02h attr=%02h/%0b last=%0b",
                                 cell_if.cell_index, cell_if.glyph, cell_if.attribute,
                                 cell_if.attribute_valid, cell_if.last);
                    end
                    void'(owed_writes.pop_front());
                end else begin
                    void'(owed_writes.pop_front());
                end
            end
            cell_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Main sequence.
    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.func      = FUNC_CHAR;
        cmd_if.char_code = '0;
        cmd_if.color     = '0;
        cmd_if.number    = '0;
        cmd_if.row       = '0;
        cmd_if.column    = '0;
        cursor_col       = '0;
        cursor_row       = '0;
        send_idle_pct    = 27;
        recv_idle_pct    = 80;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_character_writes();
        test_number_printing();
        test_cursor_moves();
        test_random_commands(35);

        send_idle_pct = 80;
        recv_idle_pct = 27;
        test_random_commands(35);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_input_stall();
        test_random_commands(25);
        cmd_if.valid <= 1'b0;

        // Let the last number finish and watch for stray writes.
        while (owed_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d commands (characters, newlines, numbers, cursor moves) gave %0d cell writes,",
                 commands_sent, writes_checked);
        $display("Summary: with idling on both channels and a %0d-cycle output stall; %0d errors.",
                 STALL_CYCLES, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #3_000_000;
        $display("Timeout: %0d writes still owed", owed_writes.size());
        $display("Verification failed");
        $finish;
    end

endmodule
